/* sv/jsu_pkg.sv */
// Shared types, character constants and decode functions for the JSON string unescaper.
package jsu_pkg;

    // Result kinds, as they appear on the result tuser field.
    typedef enum logic [3:0] {
        KIND_DATA         = 4'd0,
        KIND_CLOSED       = 4'd1,
        KIND_NO_QUOTE     = 4'd2,
        KIND_CONTROL      = 4'd3,
        KIND_BAD_ESCAPE   = 4'd4,
        KIND_BAD_HEX      = 4'd5,
        KIND_SHORT_HEX    = 4'd6,
        KIND_NO_LOW       = 4'd7,
        KIND_BAD_LOW      = 4'd8,
        KIND_LONE_LOW     = 4'd9,
        KIND_UNTERMINATED = 4'd10
    } kind_t;

    // All results caused by one input item. Every result of a burst shares the
    // kind and offset; only data bursts carry more than one byte.
    typedef struct packed {
        kind_t             kind;
        logic [1:0]        last_idx;
        logic [3:0][7:0]   data;
        logic [31:0]       offset;
    } burst_t;

    localparam logic [7:0]  CHAR_QUOTE    = 8'h22;
    localparam logic [7:0]  CHAR_BSLASH   = 8'h5C;
    localparam logic [7:0]  CHAR_U        = 8'h75;
    localparam logic [7:0]  CTRL_LIMIT    = 8'h20;
    localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
    localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Returns {known, value} for the byte after a backslash (\u is handled apart).
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h22, 8'h5C, 8'h2F: r = {1'b1, c};
            8'h62:               r = {1'b1, 8'h08};
            8'h66:               r = {1'b1, 8'h0C};
            8'h6E:               r = {1'b1, 8'h0A};
            8'h72:               r = {1'b1, 8'h0D};
            8'h74:               r = {1'b1, 8'h09};
            default:             r = 9'd0;
        endcase
        return r;
    endfunction

    // UTF-8 encoding of one code point as a data burst.
    function automatic burst_t utf8_burst(input logic [20:0] cp);
        burst_t b;
        b = '0;
        b.kind = KIND_DATA;
        if (cp <= 21'h7F) begin
            b.last_idx = 2'd0;
            b.data[0]  = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            b.last_idx = 2'd1;
            b.data[0]  = {3'b110, cp[10:6]};
            b.data[1]  = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            b.last_idx = 2'd2;
            b.data[0]  = {4'b1110, cp[15:12]};
            b.data[1]  = {2'b10, cp[11:6]};
            b.data[2]  = {2'b10, cp[5:0]};
        end else begin
            b.last_idx = 2'd3;
            b.data[0]  = {5'b11110, cp[20:18]};
            b.data[1]  = {2'b10, cp[17:12]};
            b.data[2]  = {2'b10, cp[11:6]};
            b.data[3]  = {2'b10, cp[5:0]};
        end
        return b;
    endfunction

endpackage

/* sv/jsu_front.sv */
// Front end: accepts input bytes, runs the unescape state machine and pushes result bursts.
module jsu_front #(
    parameter int OFFSET_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_op,
    input  logic [7:0]      in_byte,
    input  logic            q_full,
    output logic            push,
    output jsu_pkg::burst_t burst
);

    typedef enum logic [2:0] {
        PH_AWAIT,
        PH_BODY,
        PH_ESC,
        PH_HEX_FIRST,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX_LOW,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [15:0]            acc_reg, acc_next;
    logic [1:0]             digits_reg, digits_next;
    logic [9:0]             hi_reg, hi_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;

    logic                   take;
    logic [OFFSET_BITS-1:0] back_one;
    logic [OFFSET_BITS-1:0] back_digits;
    logic [4:0]             hex;
    logic [8:0]             esc;
    logic [15:0]            acc_new;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        hi_next     = hi_reg;
        offset_next = offset_reg;
        push        = 1'b0;
        burst       = '0;
        burst.kind  = jsu_pkg::KIND_DATA;
        back_one    = offset_reg - 1'b1;
        back_digits = offset_reg - OFFSET_BITS'(digits_reg);
        hex         = jsu_pkg::hex_digit(in_byte);
        esc         = jsu_pkg::simple_escape(in_byte);
        acc_new     = {acc_reg[11:0], hex[3:0]};

        if (take && phase_reg != PH_DONE) begin
            if (in_op) begin
                // End of input: exactly one error result, then finished.
                push         = 1'b1;
                phase_next   = PH_DONE;
                burst.offset = 32'(offset_reg);
                unique case (phase_reg)
                    PH_AWAIT:   burst.kind = jsu_pkg::KIND_NO_QUOTE;
                    PH_BODY:    burst.kind = jsu_pkg::KIND_UNTERMINATED;
                    PH_ESC:     burst.kind = jsu_pkg::KIND_BAD_ESCAPE;
                    PH_HEX_FIRST, PH_HEX_LOW:
                    begin
                        burst.kind   = jsu_pkg::KIND_SHORT_HEX;
                        burst.offset = 32'(back_digits);
                    end
                    PH_WANT_BS: burst.kind = jsu_pkg::KIND_NO_LOW;
                    default:
                    begin
                        burst.kind   = jsu_pkg::KIND_NO_LOW;
                        burst.offset = 32'(back_one);
                    end
                endcase
            end else begin
                offset_next  = offset_reg + 1'b1;
                burst.offset = 32'(offset_reg);
                unique case (phase_reg)
                    PH_AWAIT:
                    begin
                        if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                            phase_next = PH_BODY;
                        end else begin
                            push       = 1'b1;
                            burst.kind = jsu_pkg::KIND_NO_QUOTE;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_BODY:
                    begin
                        if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                            push         = 1'b1;
                            burst.kind   = jsu_pkg::KIND_CLOSED;
                            burst.offset = '0;
                            phase_next   = PH_DONE;
                        end else if (in_byte < jsu_pkg::CTRL_LIMIT) begin
                            push       = 1'b1;
                            burst.kind = jsu_pkg::KIND_CONTROL;
                            phase_next = PH_DONE;
                        end else if (in_byte == jsu_pkg::CHAR_BSLASH) begin
                            phase_next = PH_ESC;
                        end else begin
                            push          = 1'b1;
                            burst.data[0] = in_byte;
                            burst.offset  = '0;
                        end
                    end
                    PH_ESC:
                    begin
                        if (esc[8]) begin
                            push          = 1'b1;
                            burst.data[0] = esc[7:0];
                            burst.offset  = '0;
                            phase_next    = PH_BODY;
                        end else if (in_byte == jsu_pkg::CHAR_U) begin
                            acc_next    = '0;
                            digits_next = '0;
                            phase_next  = PH_HEX_FIRST;
                        end else begin
                            push       = 1'b1;
                            burst.kind = jsu_pkg::KIND_BAD_ESCAPE;
                            phase_next = PH_DONE;
                        end
                    end
                    PH_HEX_FIRST, PH_HEX_LOW:
                    begin
                        if (!hex[4]) begin
                            push       = 1'b1;
                            burst.kind = jsu_pkg::KIND_BAD_HEX;
                            phase_next = PH_DONE;
                        end else begin
                            acc_next = acc_new;
                            if (digits_reg != 2'd3) begin
                                digits_next = digits_reg + 2'd1;
                            end else begin
                                digits_next = '0;
                                if (phase_reg == PH_HEX_FIRST) begin
                                    if (acc_new >= jsu_pkg::SURR_HI_FIRST
                                        && acc_new <= jsu_pkg::SURR_HI_LAST) begin
                                        // High surrogate: keep its low ten bits for pairing.
                                        hi_next    = acc_new[9:0];
                                        phase_next = PH_WANT_BS;
                                    end else if (acc_new >= jsu_pkg::SURR_LO_FIRST
                                        && acc_new <= jsu_pkg::SURR_LO_LAST) begin
                                        push       = 1'b1;
                                        burst.kind = jsu_pkg::KIND_LONE_LOW;
                                        phase_next = PH_DONE;
                                    end else begin
                                        push       = 1'b1;
                                        burst      = jsu_pkg::utf8_burst(21'(acc_new));
                                        phase_next = PH_BODY;
                                    end
                                end else begin
                                    if (acc_new < jsu_pkg::SURR_LO_FIRST
                                        || acc_new > jsu_pkg::SURR_LO_LAST) begin
                                        push       = 1'b1;
                                        burst.kind = jsu_pkg::KIND_BAD_LOW;
                                        phase_next = PH_DONE;
                                    end else begin
                                        push       = 1'b1;
                                        burst      = jsu_pkg::utf8_burst(jsu_pkg::SUPP_BASE
                                                     + 21'({hi_reg, acc_new[9:0]}));
                                        phase_next = PH_BODY;
                                    end
                                end
                            end
                        end
                    end
                    PH_WANT_BS:
                    begin
                        if (in_byte == jsu_pkg::CHAR_BSLASH) begin
                            phase_next = PH_WANT_U;
                        end else begin
                            push       = 1'b1;
                            burst.kind = jsu_pkg::KIND_NO_LOW;
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        if (in_byte == jsu_pkg::CHAR_U) begin
                            acc_next    = '0;
                            digits_next = '0;
                            phase_next  = PH_HEX_LOW;
                        end else begin
                            push         = 1'b1;
                            burst.kind   = jsu_pkg::KIND_NO_LOW;
                            burst.offset = 32'(back_one);
                            phase_next   = PH_DONE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_AWAIT;
            acc_reg    <= '0;
            digits_reg <= '0;
            hi_reg     <= '0;
            offset_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            hi_reg     <= hi_next;
            offset_reg <= offset_next;
        end
    end

endmodule

/* sv/jsu_fifo.sv */
// Short queue of result bursts between the front end and the back end.
module jsu_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jsu_pkg::burst_t wr_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output jsu_pkg::burst_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::burst_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/jsu_back.sv */
// Back end: holds one burst in an output register and sends its results one per cycle while out_ready is high.
module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  jsu_pkg::burst_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output jsu_pkg::kind_t  out_kind,
    output logic [7:0]      out_byte,
    output logic [31:0]     out_offset,
    output logic            out_last
);

    jsu_pkg::burst_t cur_reg, cur_next;
    logic [1:0]      idx_reg, idx_next;
    logic            valid_reg, valid_next;
    logic            fire;
    logic            at_last;

    assign fire    = valid_reg && out_ready;
    assign at_last = (idx_reg == cur_reg.last_idx);
    assign q_pop   = q_not_empty && (!valid_reg || (fire && at_last));

    assign out_valid  = valid_reg;
    assign out_kind   = cur_reg.kind;
    assign out_byte   = cur_reg.data[idx_reg];
    assign out_offset = cur_reg.offset;
    assign out_last   = at_last;

    always_comb
    begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (q_pop) begin
            cur_next   = q_data;
            idx_next   = '0;
            valid_next = 1'b1;
        end else if (fire) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

/* sv/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper with UTF-8 output.
//
// The block takes one byte of a quoted JSON string per transfer, starting at the
// opening quote, and sends the unescaped content as UTF-8 bytes, followed by a
// closed result at the closing quote or by a single error result that carries
// the 0-based offset of the offending byte; after either, further input is
// consumed without results until reset. An input transfer is taken every cycle
// while the result queue has room. Each input byte yields zero to four results
// and the output side sends one result per cycle while m_axis_tready is high,
// so a run of plain characters then streams at one byte per cycle while a \u
// escape holds the output until all of its UTF-8 bytes are sent. The decode
// state machine in the front end settles each byte in the cycle it is accepted
// and pushes its whole burst into a queue of QUEUE_DEPTH bursts; the back end
// pops a burst into its output register and walks through it, so the first
// result of a byte is presented from the output register once its burst has
// passed through the queue. OFFSET_BITS sets the width of the byte counter,
// which wraps; error_offset shows its low 32 bits.
module json_string_unescape_utf8 #(
    parameter int OFFSET_BITS = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] op (end of input when high)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] error_offset
    output logic [3:0]  m_axis_tuser,   // [3:0] kind
    output logic        m_axis_tlast    // last result caused by one input byte
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_not_empty;
    jsu_pkg::burst_t q_wr_data;
    jsu_pkg::burst_t q_rd_data;
    jsu_pkg::kind_t  out_kind;
    logic [7:0]      out_byte;
    logic [31:0]     out_offset;

    // Front end: byte classification, escape and surrogate handling.
    jsu_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_byte  (s_axis_tdata),
        .q_full   (q_full),
        .push     (q_push),
        .burst    (q_wr_data)
    );

    // The queue lets the front keep taking bytes while a long burst drains.
    jsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data)
    );

    // Back end: serializes each burst onto the result stream.
    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (out_kind),
        .out_byte    (out_byte),
        .out_offset  (out_offset),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {out_offset, out_byte};
    assign m_axis_tuser = out_kind;

`ifndef NO_ASSERTIONS
    // A closed or error result is always the only result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != jsu_pkg::KIND_DATA) |-> m_axis_tlast)
        else $error("non-data result not marked last");

    // Only data results carry a byte value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != jsu_pkg::KIND_DATA) |-> m_axis_tdata[7:0] == 8'd0)
        else $error("non-data result carries a byte");

    // Data results carry no offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == jsu_pkg::KIND_DATA) |-> m_axis_tdata[39:8] == 32'd0)
        else $error("data result carries an offset");

    // A burst is popped only when the output register is free or finishing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && m_axis_tvalid) |-> (m_axis_tready && m_axis_tlast))
        else $error("burst loaded over a pending result");
`endif

endmodule
